### design/ccal_pkg.sv
// ----------------------------------------------------------------------------
// ccal_pkg
// Shared types, constants and helper functions of the calendar clock.
// ----------------------------------------------------------------------------
package ccal_pkg;

	localparam int ALARM_SLOTS = 5;
	localparam int SLOT_W      = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int CNT_W       = $clog2(ALARM_SLOTS + 1);
	localparam int ALARM_W     = 17;

	localparam logic [13:0] YEAR_MAX = 14'd9999;

	// reset date and time
	localparam logic [13:0] YEAR_RST   = 14'd2024;
	localparam logic [3:0]  MONTH_RST  = 4'd11;
	localparam logic [4:0]  DAY_RST    = 5'd3;
	localparam logic [4:0]  HOUR_RST   = 5'd1;
	localparam logic [5:0]  MINUTE_RST = 6'd59;
	localparam logic [5:0]  SECOND_RST = 6'd58;

	// command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_LOAD  = 3'd1;
	localparam logic [2:0] CMD_ADD   = 3'd2;
	localparam logic [2:0] CMD_CLEAR = 3'd3;
	localparam logic [2:0] CMD_RUN   = 3'd4;
	localparam logic [2:0] CMD_ZONE  = 3'd5;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} cal_time_t;

	// captured, range-fixed load fields
	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        leap;
		logic [1:0]  zone;
	} load_t;

	typedef struct packed {
		logic tick;
		logic load;
		logic zone;
	} tk_op_t;

	// y / 100 through reciprocal 5243 / 2^19; the fraction of an exact
	// multiple stays below 2048 for any 14-bit year
	function automatic logic leap_year(input logic [13:0] y);
		logic [27:0] prod;
		logic        div4;
		logic        div100;
		logic        div400;
		prod   = 28'(y) * 28'd5243;
		div4   = (y[1:0] == 2'd0);
		div100 = (prod[18:0] < 19'd2048);
		div400 = div100 && (prod[20:19] == 2'd0);
		return div4 && (!div100 || div400);
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		case (m) inside
			4'd2:                     len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [3:0] zone_hours(input logic [1:0] zs);
		logic [3:0] h;
		case (zs)
			2'd0:    h = 4'd0;
			2'd1:    h = 4'd3;
			2'd2:    h = 4'd9;
			default: h = 4'd10;
		endcase
		return h;
	endfunction

	function automatic logic [ALARM_W-1:0] pack_hms(input logic [4:0] h,
		input logic [5:0] m, input logic [5:0] s);
		return {h, m, s};
	endfunction

endpackage

### design/ccal_alarm_mem.sv
// ----------------------------------------------------------------------------
// ccal_alarm_mem
// Alarm table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ccal_alarm_mem (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ccal_pkg::SLOT_W-1:0]   waddr,
	input  logic [ccal_pkg::ALARM_W-1:0]  wdata,
	input  logic                          re,
	input  logic [ccal_pkg::SLOT_W-1:0]   raddr,
	output logic [ccal_pkg::ALARM_W-1:0]  rdata
);
	import ccal_pkg::*;

	logic [ALARM_W-1:0] mem [ALARM_SLOTS];
	logic [ALARM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/ccal_timekeeper.sv
// ----------------------------------------------------------------------------
// ccal_timekeeper
// Date and time registers with second tick, load and zone shift.
// ----------------------------------------------------------------------------
module ccal_timekeeper (
	input  logic                clk,
	input  logic                arst_n,
	input  ccal_pkg::tk_op_t    op,
	input  ccal_pkg::load_t     ld,
	output ccal_pkg::cal_time_t now
);
	import ccal_pkg::*;

	cal_time_t  time_q;
	cal_time_t  time_d;
	logic [3:0] zone_q;
	logic [3:0] zone_d;
	logic       leap_cur_q;
	logic       day_inc;
	logic       day_dec;
	logic [5:0] h6;
	logic [3:0] nz;
	logic [4:0] ld_len;
	logic [4:0] cur_len;

	assign nz      = zone_hours(ld.zone);
	assign h6      = 6'(time_q.hour) + 6'd24 + 6'(nz) - 6'(zone_q);
	assign ld_len  = month_len(ld.leap, ld.month);
	assign cur_len = month_len(leap_cur_q, time_q.month);

	always_comb begin
		time_d  = time_q;
		zone_d  = zone_q;
		day_inc = 1'b0;
		day_dec = 1'b0;
		if (op.load) begin
			time_d.year   = ld.year;
			time_d.month  = ld.month;
			time_d.day    = (ld.day == 5'd0 || ld.day > ld_len) ? 5'd1 : ld.day;
			time_d.hour   = ld.hour;
			time_d.minute = ld.minute;
			time_d.second = ld.second;
		end else if (op.tick) begin
			time_d.second = time_q.second + 6'd1;
			if (time_q.second >= 6'd59) begin
				time_d.second = 6'd0;
				time_d.minute = time_q.minute + 6'd1;
				if (time_q.minute >= 6'd59) begin
					time_d.minute = 6'd0;
					time_d.hour   = time_q.hour + 5'd1;
					if (time_q.hour >= 5'd23) begin
						time_d.hour = 5'd0;
						day_inc     = 1'b1;
					end
				end
			end
		end else if (op.zone) begin
			zone_d = nz;
			if (h6 >= 6'd48) begin
				time_d.hour = 5'(h6 - 6'd48);
				day_inc     = 1'b1;
			end else if (h6 >= 6'd24) begin
				time_d.hour = 5'(h6 - 6'd24);
			end else begin
				time_d.hour = 5'(h6);
				day_dec     = 1'b1;
			end
		end

		if (day_inc) begin
			if (time_q.day >= cur_len) begin
				time_d.day = 5'd1;
				if (time_q.month >= 4'd12) begin
					time_d.month = 4'd1;
					time_d.year  = (time_q.year >= YEAR_MAX) ? 14'd0 : time_q.year + 14'd1;
				end else begin
					time_d.month = time_q.month + 4'd1;
				end
			end else begin
				time_d.day = time_q.day + 5'd1;
			end
		end else if (day_dec) begin
			if (time_q.day > 5'd1) begin
				time_d.day = time_q.day - 5'd1;
			end else if (time_q.month > 4'd1) begin
				// year unchanged, so the current leap flag covers February
				time_d.month = time_q.month - 4'd1;
				time_d.day   = month_len(leap_cur_q, time_q.month - 4'd1);
			end else begin
				time_d.month = 4'd12;
				time_d.day   = 5'd31;
				time_d.year  = (time_q.year == 14'd0) ? YEAR_MAX : time_q.year - 14'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q.year   <= YEAR_RST;
			time_q.month  <= MONTH_RST;
			time_q.day    <= DAY_RST;
			time_q.hour   <= HOUR_RST;
			time_q.minute <= MINUTE_RST;
			time_q.second <= SECOND_RST;
			zone_q        <= 4'd0;
			leap_cur_q    <= leap_year(YEAR_RST);
		end else begin
			time_q     <= time_d;
			zone_q     <= zone_d;
			// registered from the year, so it lags it; updates never come back to back
			leap_cur_q <= leap_year(time_q.year);
		end
	end

	assign now = time_q;

endmodule

### design/calendar_clock_with_alarms.sv
// ----------------------------------------------------------------------------
// calendar_clock_with_alarms
// Calendar clock with Gregorian date, time zone shift and an alarm table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one command beat (cmd plus the
//   load, alarm, zone and run fields). Output channel out_valid/out_ready
//   returns one result beat per command: date, time, displayed hour, PM flag,
//   alarm hit, alarm count and status. cfg_we/cfg_wdata writes the
//   twelve-hour display mode; write it only while no command is in flight.
//   Sequence: a command passes from accept through the EXEC and DONE
//   states into the result register. A tick on a running clock with alarms
//   stored also scans the alarm table, one entry per cycle through the
//   table's read port, then a DRAIN state waits for the last read data.
//   in_ready is high whenever the sequencer is idle, also while an earlier
//   result still waits in the output register; a finished command holds in
//   its result state until that register is free.
//   Reset: date 2024-11-03, time 01:59:58, zone offset 0, clock stopped,
//   alarm table empty, 24-hour display. Table contents are not cleared.
// ----------------------------------------------------------------------------
module calendar_clock_with_alarms (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [13:0] year_in,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [4:0]  hour_in,
	input  logic [5:0]  minute_in,
	input  logic [5:0]  second_in,
	input  logic [1:0]  zone_select,
	input  logic        run_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] year_out,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [4:0]  hour_out,
	output logic [5:0]  minute_out,
	output logic [5:0]  second_out,
	output logic [4:0]  shown_hour,
	output logic        pm_flag,
	output logic        alarm_hit,
	output logic [2:0]  alarm_count,
	output logic        status
);
	import ccal_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic               twelve_q;
	logic               running_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]  scan_idx_q;
	logic               rd_vld_s1;
	logic               hit_q;
	logic               status_q;
	logic [2:0]         cmd_q;
	logic               run_q;
	load_t              ld_q;
	load_t              ld_d;
	logic [13:0]        year_sat;

	tk_op_t             op;
	cal_time_t          now;
	logic               accept;
	logic               exec;
	logic               out_free;
	logic               mem_we;
	logic               mem_re;
	logic [ALARM_W-1:0] mem_rdata;
	logic               table_full;

	logic               out_valid_q;
	cal_time_t          out_time_q;
	logic [4:0]         shown_q;
	logic               pm_q;
	logic               hit_out_q;
	logic [2:0]         count_out_q;
	logic               status_out_q;
	logic [4:0]         shown_d;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign exec       = (state_q == ST_EXEC);
	assign out_free   = !out_valid_q || out_ready;
	assign table_full = (cnt_q >= CNT_W'(ALARM_SLOTS));

	// range fixing on capture; day is fixed in the timekeeper
	assign year_sat = (year_in > YEAR_MAX) ? YEAR_MAX : year_in;
	always_comb begin
		ld_d.year   = year_sat;
		ld_d.month  = (month_in == 4'd0 || month_in > 4'd12) ? 4'd1 : month_in;
		ld_d.day    = day_in;
		ld_d.hour   = (hour_in >= 5'd24) ? 5'd0 : hour_in;
		ld_d.minute = (minute_in >= 6'd60) ? 6'd0 : minute_in;
		ld_d.second = (second_in >= 6'd60) ? 6'd0 : second_in;
		ld_d.leap   = leap_year(year_sat);
		ld_d.zone   = zone_select;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ld_q  <= ld_d;
			cmd_q <= cmd;
			run_q <= run_in;
		end
	end

	assign op.tick = exec && (cmd_q == CMD_TICK) && running_q;
	assign op.load = exec && (cmd_q == CMD_LOAD);
	assign op.zone = exec && (cmd_q == CMD_ZONE);

	ccal_timekeeper u_tk (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.ld     (ld_q),
		.now    (now)
	);

	// table writes happen only in EXEC, reads only in SCAN: no overlap
	assign mem_we = exec && (cmd_q == CMD_ADD) && !table_full;
	assign mem_re = (state_q == ST_SCAN);

	ccal_alarm_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (SLOT_W'(cnt_q)),
		.wdata (pack_hms(ld_q.hour, ld_q.minute, ld_q.second)),
		.re    (mem_re),
		.raddr (scan_idx_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			twelve_q   <= 1'b0;
			running_q  <= 1'b0;
			cnt_q      <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			status_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				twelve_q <= cfg_wdata;
			end
			rd_vld_s1 <= mem_re;
			if (rd_vld_s1 && mem_rdata == pack_hms(now.hour, now.minute, now.second)) begin
				hit_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q    <= 1'b0;
						status_q <= 1'b0;
						state_q  <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					scan_idx_q <= '0;
					// a running tick with stored alarms walks the table
					state_q    <= (cmd_q == CMD_TICK && running_q && cnt_q != '0) ?
						ST_SCAN : ST_DONE;
					case (cmd_q)
						CMD_ADD: begin
							if (table_full) begin
								status_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						CMD_CLEAR: cnt_q     <= '0;
						CMD_RUN:   running_q <= run_q;
						default: ;
					endcase
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + 1'b1;
					if (scan_idx_q == SLOT_W'(cnt_q - 1'b1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		shown_d = now.hour;
		if (twelve_q) begin
			shown_d = (now.hour >= 5'd12) ? now.hour - 5'd12 : now.hour;
			if (shown_d == 5'd0) begin
				shown_d = 5'd12;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_time_q   <= now;
			shown_q      <= shown_d;
			pm_q         <= (now.hour >= 5'd12);
			hit_out_q    <= hit_q;
			count_out_q  <= 3'(cnt_q);
			status_out_q <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign year_out    = out_time_q.year;
	assign month_out   = out_time_q.month;
	assign day_out     = out_time_q.day;
	assign hour_out    = out_time_q.hour;
	assign minute_out  = out_time_q.minute;
	assign second_out  = out_time_q.second;
	assign shown_hour  = shown_q;
	assign pm_flag     = pm_q;
	assign alarm_hit   = hit_out_q;
	assign alarm_count = count_out_q;
	assign status      = status_out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ALARM_SLOTS))
		else $error("alarm count beyond table size");

	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DRAIN) |-> !mem_we)
		else $error("table write during scan");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (CNT_W'(scan_idx_q) < cnt_q))
		else $error("scan read past stored alarms");

	a_hit_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && hit_q) |-> (cmd_q == CMD_TICK && running_q && !status_q))
		else $error("alarm hit on a non-tick command");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (month_out >= 4'd1 && month_out <= 4'd12 && hour_out < 5'd24))
		else $error("result time out of range");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calendar clock: directed corner cases, then
// random command runs under three idle mixes and both display modes.
// ----------------------------------------------------------------------------
module tb;
	import ccal_pkg::*;

	// codes the block must ignore
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [1:0]  zone;
		logic        run;
	} cmd_beat_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [4:0]  shown;
		logic        pm;
		logic        hit;
		logic [2:0]  count;
		logic        status;
	} result_t;

	class cal_scoreboard;
		bit [13:0] year;
		bit [3:0]  month;
		bit [4:0]  day;
		bit [4:0]  hour;
		bit [5:0]  minute;
		bit [5:0]  second;
		bit [3:0]  zone_hrs;
		bit        running;
		bit        twelve_hr;
		bit [16:0] alarm_tab [ALARM_SLOTS];
		int        n_alarms;
		result_t   expected_times [$];
		int        errors;

		function new();
			year = 14'd2024;
			month = 4'd11;
			day = 5'd3;
			hour = 5'd1;
			minute = 6'd59;
			second = 6'd58;
			zone_hrs = 4'd0;
			running = 1'b0;
			twelve_hr = 1'b0;
			n_alarms = 0;
			errors = 0;
		endfunction

		function int month_days(bit [13:0] y, bit [3:0] m);
			bit lp;
			lp = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
			case (m) inside
				4'd2:                    return lp ? 29 : 28;
				4'd4, 4'd6, 4'd9, 4'd11: return 30;
				default:                 return 31;
			endcase
		endfunction

		function void advance_day();
			if (day < month_days(year, month)) begin
				day++;
			end else begin
				day = 5'd1;
				if (month == 4'd12) begin
					month = 4'd1;
					year = (year >= 14'd9999) ? 14'd0 : year + 14'd1;
				end else begin
					month++;
				end
			end
		endfunction

		function void apply_command(cmd_beat_t b);
			bit [4:0]  h;
			bit [5:0]  mi;
			bit [5:0]  s;
			bit [13:0] y;
			bit [3:0]  mo;
			bit [3:0]  nz;
			int        sum;
			bit        hit;
			bit        full;
			result_t   r;
			h = (b.hour >= 24) ? 5'd0 : b.hour;
			mi = (b.minute >= 60) ? 6'd0 : b.minute;
			s = (b.second >= 60) ? 6'd0 : b.second;
			hit = 1'b0;
			full = 1'b0;
			case (b.op)
				CMD_TICK: begin
					if (running) begin
						if (second == 6'd59) begin
							second = 6'd0;
							if (minute == 6'd59) begin
								minute = 6'd0;
								if (hour == 5'd23) begin
									hour = 5'd0;
									advance_day();
								end else begin
									hour++;
								end
							end else begin
								minute++;
							end
						end else begin
							second++;
						end
						for (int i = 0; i < n_alarms; i++)
							if (alarm_tab[i] == {hour, minute, second})
								hit = 1'b1;
					end
				end
				CMD_LOAD: begin
					y = (b.year > 14'd9999) ? 14'd9999 : b.year;
					mo = (b.month == 4'd0 || b.month > 4'd12) ? 4'd1 : b.month;
					year = y;
					month = mo;
					day = (b.day == 5'd0 || b.day > month_days(y, mo)) ? 5'd1 : b.day;
					hour = h;
					minute = mi;
					second = s;
				end
				CMD_ADD: begin
					if (n_alarms < ALARM_SLOTS) begin
						alarm_tab[n_alarms] = {h, mi, s};
						n_alarms++;
					end else begin
						full = 1'b1;
					end
				end
				CMD_CLEAR: n_alarms = 0;
				CMD_RUN:   running = b.run;
				CMD_ZONE: begin
					case (b.zone)
						2'd0:    nz = 4'd0;
						2'd1:    nz = 4'd3;
						2'd2:    nz = 4'd9;
						default: nz = 4'd10;
					endcase
					sum = int'(hour) + 24 + int'(nz) - int'(zone_hrs);
					zone_hrs = nz;
					if (sum >= 48) begin
						hour = 5'(sum - 48);
						advance_day();
					end else if (sum >= 24) begin
						hour = 5'(sum - 24);
					end else begin
						hour = 5'(sum);
						// borrow one day
						if (day > 5'd1) begin
							day--;
						end else begin
							if (month > 4'd1) begin
								month--;
							end else begin
								month = 4'd12;
								year = (year == 14'd0) ? 14'd9999 : year - 14'd1;
							end
							day = 5'(month_days(year, month));
						end
					end
				end
				default: ;
			endcase
			r.year = year;
			r.month = month;
			r.day = day;
			r.hour = hour;
			r.minute = minute;
			r.second = second;
			r.shown = twelve_hr ? ((hour % 12 == 0) ? 5'd12 : 5'(hour % 12)) : hour;
			r.pm = (hour >= 5'd12);
			r.hit = hit;
			r.count = 3'(n_alarms);
			r.status = full;
			expected_times.push_back(r);
		endfunction

		function void check_field(string name, logic [13:0] want, logic [13:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_times.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_times.pop_front();
			check_field("year_out", want.year, got.year);
			check_field("month_out", want.month, got.month);
			check_field("day_out", want.day, got.day);
			check_field("hour_out", want.hour, got.hour);
			check_field("minute_out", want.minute, got.minute);
			check_field("second_out", want.second, got.second);
			check_field("shown_hour", want.shown, got.shown);
			check_field("pm_flag", want.pm, got.pm);
			check_field("alarm_hit", want.hit, got.hit);
			check_field("alarm_count", want.count, got.count);
			check_field("status", want.status, got.status);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [13:0] year_in;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic [4:0]  hour_in;
	logic [5:0]  minute_in;
	logic [5:0]  second_in;
	logic [1:0]  zone_select;
	logic        run_in;
	logic        out_valid;
	logic        out_ready;
	logic [13:0] year_out;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic [5:0]  second_out;
	logic [4:0]  shown_hour;
	logic        pm_flag;
	logic        alarm_hit;
	logic [2:0]  alarm_count;
	logic        status;

	cal_scoreboard sb = new();
	int beats_sent = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int phase;
	int stop_at;
	int pick;

	calendar_clock_with_alarms i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.year_in     (year_in),
		.month_in    (month_in),
		.day_in      (day_in),
		.hour_in     (hour_in),
		.minute_in   (minute_in),
		.second_in   (second_in),
		.zone_select (zone_select),
		.run_in      (run_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.year_out    (year_out),
		.month_out   (month_out),
		.day_out     (day_out),
		.hour_out    (hour_out),
		.minute_out  (minute_out),
		.second_out  (second_out),
		.shown_hour  (shown_hour),
		.pm_flag     (pm_flag),
		.alarm_hit   (alarm_hit),
		.alarm_count (alarm_count),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: FAIL");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_result({year_out, month_out, day_out, hour_out, minute_out,
				second_out, shown_hour, pm_flag, alarm_hit, alarm_count, status});
	end

	// random filler for every field; callers overwrite what matters
	function automatic cmd_beat_t noise(input logic [2:0] op);
		cmd_beat_t b;
		b.op = op;
		b.year = 14'($urandom);
		b.month = 4'($urandom);
		b.day = 5'($urandom);
		b.hour = 5'($urandom);
		b.minute = 6'($urandom);
		b.second = 6'($urandom);
		b.zone = 2'($urandom);
		b.run = 1'($urandom);
		return b;
	endfunction

	function automatic int pick_year();
		case ($urandom_range(6))
			0:       return 0;
			1:       return 1900;
			2:       return 2000;
			3:       return 2100;
			4:       return 9999;
			5:       return 2024;
			default: return $urandom_range(9999);
		endcase
	endfunction

	// entered and left at a falling edge; valid stays up across back-to-back beats
	task automatic send_beat(input cmd_beat_t b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= b.op;
		year_in <= b.year;
		month_in <= b.month;
		day_in <= b.day;
		hour_in <= b.hour;
		minute_in <= b.minute;
		second_in <= b.second;
		zone_select <= b.zone;
		run_in <= b.run;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.apply_command(b);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_times.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_mode(input logic v);
		wait_drain();
		repeat (12) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.twelve_hr = v;
	endtask

	task automatic plain(input logic [2:0] op);
		send_beat(noise(op));
	endtask

	task automatic load_time(input int y, input int mo, input int d, input int h,
		input int mi, input int s);
		cmd_beat_t b;
		b = noise(CMD_LOAD);
		b.year = 14'(y);
		b.month = 4'(mo);
		b.day = 5'(d);
		b.hour = 5'(h);
		b.minute = 6'(mi);
		b.second = 6'(s);
		send_beat(b);
	endtask

	task automatic arm_alarm(input int h, input int mi, input int s);
		cmd_beat_t b;
		b = noise(CMD_ADD);
		b.hour = 5'(h);
		b.minute = 6'(mi);
		b.second = 6'(s);
		send_beat(b);
	endtask

	task automatic set_zone(input int zs);
		cmd_beat_t b;
		b = noise(CMD_ZONE);
		b.zone = 2'(zs);
		send_beat(b);
	endtask

	task automatic set_run(input logic r);
		cmd_beat_t b;
		b = noise(CMD_RUN);
		b.run = r;
		send_beat(b);
	endtask

	// load just before a rollover, arm alarms a few seconds ahead, tick through
	task automatic alarm_run();
		int h;
		int m;
		int s;
		int total;
		if ($urandom_range(9) < 7)
			plain(CMD_CLEAR);
		h = $urandom_range(1) ? 23 : $urandom_range(23);
		m = $urandom_range(1) ? 59 : $urandom_range(59);
		s = $urandom_range(50, 59);
		load_time(pick_year(), $urandom_range(1, 12), $urandom_range(27, 31), h, m, s);
		repeat ($urandom_range(1, 4)) begin
			total = (h * 3600 + m * 60 + s + $urandom_range(1, 8)) % 86400;
			arm_alarm(total / 3600, (total / 60) % 60, total % 60);
		end
		set_run($urandom_range(9) != 0);
		repeat ($urandom_range(2, 10)) plain(CMD_TICK);
	endtask

	// hours near midnight and month edges so zone shifts carry and borrow
	task automatic zone_run();
		int h;
		if ($urandom_range(3) == 0)
			h = $urandom_range(23);
		else
			h = $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(20, 23);
		load_time(pick_year(), $urandom_range(1, 12),
			$urandom_range(1) ? 1 : $urandom_range(28, 31), h,
			$urandom_range(59), $urandom_range(59));
		repeat ($urandom_range(1, 4)) set_zone($urandom_range(3));
		repeat ($urandom_range(0, 3)) plain(CMD_TICK);
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_TICK;
		year_in <= '0;
		month_in <= '0;
		day_in <= '0;
		hour_in <= '0;
		minute_in <= '0;
		second_in <= '0;
		zone_select <= '0;
		run_in <= 1'b0;
		out_ready <= 1'b0;
		send_idle = 34;
		recv_idle = 70;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_mode(1'b0);

		// directed corners
		plain(CMD_TICK);
		set_run(1'b1);
		plain(CMD_TICK);
		plain(CMD_TICK);
		load_time(16383, 15, 31, 31, 63, 63);
		load_time(1900, 2, 29, 12, 0, 0);
		load_time(2000, 2, 29, 11, 59, 59);
		plain(CMD_TICK);
		load_time(2024, 0, 0, 0, 0, 0);
		load_time(9999, 12, 31, 23, 59, 58);
		arm_alarm(31, 63, 63);
		arm_alarm(23, 59, 59);
		arm_alarm(0, 0, 1);
		arm_alarm(0, 0, 2);
		arm_alarm(12, 0, 0);
		arm_alarm(1, 1, 1);
		plain(CMD_TICK);
		plain(CMD_TICK);
		plain(CMD_CLEAR);
		plain(CMD_TICK);
		set_zone(3);
		set_zone(3);
		load_time(0, 1, 1, 5, 0, 0);
		set_zone(0);
		set_zone(2);
		plain(CMD_SPARE_A);
		plain(CMD_SPARE_B);
		set_run(1'b0);
		plain(CMD_TICK);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 34;
					recv_idle = 70;
				end
				1: begin
					send_idle = 70;
					recv_idle = 34;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			write_mode(phase != 1);
			stop_at = beats_sent + 170;
			while (beats_sent < stop_at) begin
				pick = $urandom_range(99);
				if (pick < 45)
					alarm_run();
				else if (pick < 70)
					zone_run();
				else
					plain(3'($urandom_range(7)));
				if ($urandom_range(19) == 0)
					wait_drain();
			end
		end

		wait_drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
